// ===== rtl/core/dcc_pkt_pkg.sv =====
// DCC packet builder package: request, stage and packet types, kind codes,
// fixed instruction byte values and range limits.
// No dependencies; imported by every module of the block.
package dcc_pkt_pkg;

    localparam logic [4:0] KIND_GEN1        = 5'd0;
    localparam logic [4:0] KIND_GEN2        = 5'd1;
    localparam logic [4:0] KIND_GEN3        = 5'd2;
    localparam logic [4:0] KIND_GEN4        = 5'd3;
    localparam logic [4:0] KIND_ACC_BASIC   = 5'd4;
    localparam logic [4:0] KIND_ACC_OPS     = 5'd5;
    localparam logic [4:0] KIND_ACC_LEGACY  = 5'd6;
    localparam logic [4:0] KIND_SIG_ASPECT  = 5'd7;
    localparam logic [4:0] KIND_SACC_BASIC  = 5'd8;
    localparam logic [4:0] KIND_SACC_OPS    = 5'd9;
    localparam logic [4:0] KIND_SACC_LEGACY = 5'd10;
    localparam logic [4:0] KIND_OPS_CV      = 5'd11;
    localparam logic [4:0] KIND_SPD128      = 5'd12;
    localparam logic [4:0] KIND_SPD28       = 5'd13;
    localparam logic [4:0] KIND_SPD14       = 5'd14;
    localparam logic [4:0] KIND_FN_F0_F4    = 5'd15;
    localparam logic [4:0] KIND_FN_F5_F8    = 5'd16;
    localparam logic [4:0] KIND_FN_F9_F12   = 5'd17;
    localparam logic [4:0] KIND_FN_F13_F20  = 5'd18;
    localparam logic [4:0] KIND_FN_F21_F28  = 5'd19;
    localparam logic [4:0] KIND_ANALOG      = 5'd20;
    localparam logic [4:0] KIND_CONSIST     = 5'd21;

    localparam logic [7:0]  BYTE_LONG_HEAD  = 8'hC0;
    localparam logic [7:0]  BYTE_CV_WRITE   = 8'hEC;
    localparam logic [7:0]  BYTE_SPD128     = 8'h3F;
    localparam logic [7:0]  BYTE_F13_F20    = 8'hDE;
    localparam logic [7:0]  BYTE_F21_F28    = 8'hDF;
    localparam logic [7:0]  BYTE_ANALOG     = 8'h3D;
    localparam logic [7:0]  BYTE_F5_F8      = 8'hB0;
    localparam logic [7:0]  BYTE_F9_F12     = 8'hA0;
    localparam logic [7:0]  BYTE_F0_F4      = 8'h80;
    localparam logic [7:0]  BYTE_SPD_FWD    = 8'h60;
    localparam logic [7:0]  BYTE_SPD_REV    = 8'h40;
    localparam logic [7:0]  BYTE_CONS_FWD   = 8'h12;
    localparam logic [7:0]  BYTE_CONS_REV   = 8'h13;
    localparam logic [7:0]  BYTE_ACC_LOW    = 8'h80;

    localparam logic [13:0] SHORT_ADDR_MAX  = 14'd127;
    localparam logic [13:0] LONG_ADDR_MAX   = 14'd10239;
    localparam logic [13:0] ACC_NUM0_MAX    = 14'd2043;
    localparam logic [9:0]  OPS_CV_MAX      = 10'd512;
    localparam logic [7:0]  LVL_MAX_128     = 8'd127;
    localparam logic [7:0]  LVL_MAX_28      = 8'd28;
    localparam logic [7:0]  LVL_MAX_14      = 8'd15;
    localparam logic [7:0]  LVL_MAX_ASPECT  = 8'd31;
    localparam logic [7:0]  LVL_MAX_CHAN    = 8'd7;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [13:0] address;
        logic        long_addr;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
        logic [7:0]  byte_d;
        logic [9:0]  cv_number;
        logic [7:0]  cv_data;
        logic [7:0]  level;
        logic        flag_bit;
        logic [7:0]  func_bits;
    } req_t;

    typedef struct packed {
        req_t        req;
        logic        ok;
        logic [8:0]  acc_addr;
        logic [1:0]  pair;
        logic [9:0]  cvm1;
    } chk_t;

    typedef struct packed {
        logic [5:0][7:0] b;
        logic [2:0]      n;
        logic            rej;
    } form_t;

    typedef struct packed {
        logic [6:0][7:0] b;
        logic [2:0]      cnt;
        logic            rej;
    } pkt_t;

endpackage

// ===== rtl/core/dcc_pkt_check.sv =====
// DCC packet builder stage one: range checks, derived accessory address, pair and CV offset.
// Depends on dcc_pkt_pkg.
module dcc_pkt_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcc_pkt_pkg::req_t  in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output dcc_pkt_pkg::chk_t  out_chk
);
    import dcc_pkt_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    chk_t        chk_reg;
    chk_t        chk_next;
    logic [13:0] num0;
    logic [8:0]  dec9;
    logic        loco_ok;
    logic        acc_ok;
    logic        div_ok;
    logic        cv_nz;

    always_comb
    begin
        num0    = in_req.address - 14'd1;
        dec9    = num0[10:2] + 9'd1;
        loco_ok = in_req.long_addr ? (in_req.address <= LONG_ADDR_MAX)
                                   : (in_req.address <= SHORT_ADDR_MAX);
        acc_ok  = (in_req.address != 14'd0) && (in_req.address[13:9] == 5'd0);
        div_ok  = (in_req.address != 14'd0) && (num0 <= ACC_NUM0_MAX);
        cv_nz   = (in_req.cv_number != 10'd0);
    end

    always_comb
    begin
        chk_next.req  = in_req;
        chk_next.pair = num0[1:0];
        chk_next.cvm1 = in_req.cv_number - 10'd1;
        chk_next.acc_addr = dec9;
        chk_next.ok   = 1'b0;
        case (in_req.req_type)
            KIND_GEN1, KIND_GEN2, KIND_GEN3, KIND_GEN4:
                chk_next.ok = loco_ok;
            KIND_ACC_BASIC:
            begin
                chk_next.acc_addr = in_req.address[8:0];
                chk_next.ok = acc_ok && (in_req.level <= LVL_MAX_CHAN);
            end
            KIND_ACC_OPS:
            begin
                chk_next.acc_addr = in_req.address[8:0];
                chk_next.ok = acc_ok && (in_req.level <= LVL_MAX_CHAN) && cv_nz;
            end
            KIND_ACC_LEGACY:
            begin
                chk_next.acc_addr = in_req.address[8:0];
                chk_next.ok = acc_ok && cv_nz;
            end
            KIND_SIG_ASPECT:
                chk_next.ok = div_ok && (in_req.level <= LVL_MAX_ASPECT);
            KIND_SACC_BASIC:
                chk_next.ok = div_ok;
            KIND_SACC_OPS, KIND_SACC_LEGACY:
                chk_next.ok = div_ok && cv_nz;
            KIND_OPS_CV:
                chk_next.ok = loco_ok && cv_nz && (in_req.cv_number <= OPS_CV_MAX);
            KIND_SPD128, KIND_CONSIST:
                chk_next.ok = loco_ok && (in_req.level <= LVL_MAX_128);
            KIND_SPD28:
                chk_next.ok = loco_ok && (in_req.level <= LVL_MAX_28);
            KIND_SPD14:
                chk_next.ok = loco_ok && (in_req.level <= LVL_MAX_14);
            KIND_FN_F0_F4, KIND_FN_F5_F8, KIND_FN_F9_F12, KIND_FN_F13_F20,
            KIND_FN_F21_F28, KIND_ANALOG:
                chk_next.ok = loco_ok;
            default:
                chk_next.ok = 1'b0;
        endcase
    end

    assign in_ready  = !vld_reg || out_ready;
    assign vld_next  = in_ready ? in_valid : vld_reg;
    assign out_valid = vld_reg;
    assign out_chk   = chk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            chk_reg <= chk_next;
    end

endmodule

// ===== rtl/core/dcc_pkt_form.sv =====
// DCC packet builder stage two: address and instruction bytes of the packet.
// Depends on dcc_pkt_pkg.
module dcc_pkt_form (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcc_pkt_pkg::chk_t  in_chk,
    output logic               out_valid,
    input  logic               out_ready,
    output dcc_pkt_pkg::form_t out_form
);
    import dcc_pkt_pkg::*;

    logic            vld_reg;
    logic            vld_next;
    form_t           form_reg;
    form_t           form_next;
    logic [3:0][7:0] ins;
    logic [2:0]      ins_n;
    logic            is_acc;
    logic [1:0][7:0] acc_b;
    logic [2:0][7:0] cv_b;
    logic [7:0]      low_b;
    logic [2:0]      ah;
    logic [4:0]      spd28;
    logic [7:0]      dir_b;
    req_t            r;

    always_comb
    begin
        r      = in_chk.req;
        ah     = ~in_chk.acc_addr[8:6];
        low_b  = BYTE_ACC_LOW | {2'b00, in_chk.acc_addr[5:0]};
        cv_b[0] = BYTE_CV_WRITE | {6'd0, in_chk.cvm1[9:8]};
        cv_b[1] = in_chk.cvm1[7:0];
        cv_b[2] = r.cv_data;
        spd28  = {r.level[0], r.level[4:1] + {3'd0, (r.level != 8'd0)}};
        dir_b  = r.flag_bit ? BYTE_SPD_FWD : BYTE_SPD_REV;
        ins    = '0;
        ins_n  = 3'd0;
        acc_b  = '0;
        is_acc = 1'b0;
        form_next = '0;
        case (r.req_type)
            KIND_GEN1, KIND_GEN2, KIND_GEN3, KIND_GEN4:
            begin
                ins[0] = r.byte_a;
                if (r.req_type != KIND_GEN1)
                    ins[1] = r.byte_b;
                if ((r.req_type == KIND_GEN3) || (r.req_type == KIND_GEN4))
                    ins[2] = r.byte_c;
                if (r.req_type == KIND_GEN4)
                    ins[3] = r.byte_d;
                ins_n = r.req_type[2:0] + 3'd1;
            end
            KIND_ACC_BASIC, KIND_ACC_OPS:
            begin
                is_acc   = 1'b1;
                acc_b[0] = low_b;
                acc_b[1] = {1'b1, ah, r.flag_bit, r.level[2:0]};
            end
            KIND_SACC_BASIC, KIND_SACC_OPS:
            begin
                is_acc   = 1'b1;
                acc_b[0] = low_b;
                acc_b[1] = {1'b1, ah, 1'b1, in_chk.pair,
                            (r.req_type == KIND_SACC_BASIC) & r.flag_bit};
            end
            KIND_ACC_LEGACY, KIND_SACC_LEGACY:
            begin
                is_acc   = 1'b1;
                acc_b[0] = low_b;
                acc_b[1] = {1'b0, ah, 2'b11, in_chk.cvm1[9:8]};
            end
            KIND_SIG_ASPECT:
            begin
                is_acc   = 1'b1;
                acc_b[0] = low_b;
                acc_b[1] = {1'b0, ah, 1'b0, in_chk.pair, 1'b1};
            end
            KIND_OPS_CV:
            begin
                ins[2:0] = cv_b;
                ins_n    = 3'd3;
            end
            KIND_SPD128:
            begin
                ins[0] = BYTE_SPD128;
                ins[1] = {r.flag_bit, r.level[6:0]};
                ins_n  = 3'd2;
            end
            KIND_SPD28:
            begin
                ins[0] = dir_b | {3'd0, spd28};
                ins_n  = 3'd1;
            end
            KIND_SPD14:
            begin
                ins[0] = dir_b | {3'd0, r.func_bits[0], r.level[3:0]};
                ins_n  = 3'd1;
            end
            KIND_FN_F0_F4:
            begin
                ins[0] = BYTE_F0_F4 | {3'd0, r.func_bits[0], r.func_bits[4:1]};
                ins_n  = 3'd1;
            end
            KIND_FN_F5_F8:
            begin
                ins[0] = BYTE_F5_F8 | {4'd0, r.func_bits[3:0]};
                ins_n  = 3'd1;
            end
            KIND_FN_F9_F12:
            begin
                ins[0] = BYTE_F9_F12 | {4'd0, r.func_bits[3:0]};
                ins_n  = 3'd1;
            end
            KIND_FN_F13_F20:
            begin
                ins[0] = BYTE_F13_F20;
                ins[1] = r.func_bits;
                ins_n  = 3'd2;
            end
            KIND_FN_F21_F28:
            begin
                ins[0] = BYTE_F21_F28;
                ins[1] = r.func_bits;
                ins_n  = 3'd2;
            end
            KIND_ANALOG:
            begin
                ins[0] = BYTE_ANALOG;
                ins[1] = r.byte_a;
                ins[2] = r.byte_b;
                ins_n  = 3'd3;
            end
            default:
            begin
                ins[0] = r.flag_bit ? BYTE_CONS_FWD : BYTE_CONS_REV;
                ins[1] = r.level;
                ins_n  = 3'd2;
            end
        endcase

        if (!in_chk.ok)
        begin
            form_next.rej = 1'b1;
        end
        else if (is_acc)
        begin
            form_next.b[1:0] = acc_b;
            form_next.n      = 3'd2;
            case (r.req_type)
                KIND_ACC_OPS, KIND_SACC_OPS:
                begin
                    form_next.b[4:2] = cv_b;
                    form_next.n      = 3'd5;
                end
                KIND_ACC_LEGACY, KIND_SACC_LEGACY:
                begin
                    form_next.b[3:2] = cv_b[2:1];
                    form_next.n      = 3'd4;
                end
                KIND_SIG_ASPECT:
                begin
                    form_next.b[2] = {3'd0, r.level[4:0]};
                    form_next.n    = 3'd3;
                end
                default:
                    form_next.n = 3'd2;
            endcase
        end
        else if (r.long_addr)
        begin
            form_next.b[0]   = BYTE_LONG_HEAD | {2'b00, r.address[13:8]};
            form_next.b[1]   = r.address[7:0];
            form_next.b[5:2] = ins;
            form_next.n      = ins_n + 3'd2;
        end
        else
        begin
            form_next.b[0]   = r.address[7:0];
            form_next.b[4:1] = ins;
            form_next.n      = ins_n + 3'd1;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign vld_next  = in_ready ? in_valid : vld_reg;
    assign out_valid = vld_reg;
    assign out_form  = form_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            form_reg <= form_next;
    end

endmodule

// ===== rtl/core/dcc_pkt_seal.sv =====
// DCC packet builder stage three: error byte and final packet length.
// Depends on dcc_pkt_pkg.
module dcc_pkt_seal (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcc_pkt_pkg::form_t in_form,
    output logic               out_valid,
    input  logic               out_ready,
    output dcc_pkt_pkg::pkt_t  out_pkt
);
    import dcc_pkt_pkg::*;

    logic            vld_reg;
    logic            vld_next;
    pkt_t            pkt_reg;
    pkt_t            pkt_next;
    logic [7:0]      err_b;
    logic [6:0][7:0] bext;

    always_comb
    begin
        err_b = in_form.b[0] ^ in_form.b[1] ^ in_form.b[2]
              ^ in_form.b[3] ^ in_form.b[4] ^ in_form.b[5];
        bext  = {8'd0, in_form.b};
        pkt_next = '0;
        if (in_form.rej)
        begin
            pkt_next.rej = 1'b1;
            pkt_next.cnt = 3'd1;
        end
        else
        begin
            pkt_next.cnt = in_form.n + 3'd1;
            for (int i = 0; i < 7; i++)
            begin
                if (3'(i) < in_form.n)
                    pkt_next.b[i] = bext[i];
                else if (3'(i) == in_form.n)
                    pkt_next.b[i] = err_b;
                else
                    pkt_next.b[i] = 8'd0;
            end
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign vld_next  = in_ready ? in_valid : vld_reg;
    assign out_valid = vld_reg;
    assign out_pkt   = pkt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pkt_reg <= pkt_next;
    end

endmodule

// ===== rtl/core/dcc_pkt_serial.sv =====
// DCC packet builder output stage: shifts a packet out one byte per transfer.
// Depends on dcc_pkt_pkg.
module dcc_pkt_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dcc_pkt_pkg::pkt_t in_pkt,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic              out_rej
);
    import dcc_pkt_pkg::*;

    logic [2:0]      rem_reg;
    logic [2:0]      rem_next;
    logic [6:0][7:0] sh_reg;
    logic            rej_reg;
    logic            xfer;
    logic            load;

    assign out_valid = (rem_reg != 3'd0);
    assign out_last  = (rem_reg == 3'd1);
    assign out_byte  = sh_reg[0];
    assign out_rej   = rej_reg;
    assign xfer      = out_valid && out_ready;
    assign in_ready  = !out_valid || (out_ready && out_last);
    assign load      = in_valid && in_ready;

    always_comb
    begin
        if (load)
            rem_next = in_pkt.cnt;
        else if (xfer)
            rem_next = rem_reg - 3'd1;
        else
            rem_next = rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 3'd0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sh_reg  <= in_pkt.b;
            rej_reg <= in_pkt.rej;
        end
        else if (xfer)
        begin
            sh_reg <= {8'd0, sh_reg[6:1]};
        end
    end

    a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rej |-> out_last)
        else $error("reject result not marked last");

    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rej |-> out_byte == 8'd0)
        else $error("reject result carries a non-zero byte");

    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !out_last |=> out_valid && !out_rej)
        else $error("packet broken off before its error byte");

    a_load_rej: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_pkt.rej |=> out_valid && out_rej && out_last)
        else $error("rejected request not shown as single result");

endmodule

// ===== rtl/core/dcc_packet_builder_top.sv =====
// DCC packet builder top level: check, form, seal and output stages in a chain.
// Path: a request passes the check, form, seal and output stage registers before
// its first byte is offered. Throughput: one byte per cycle while m_tready is high;
// a packet held in the seal stage follows its predecessor's last byte with no gap.
// Reset: rst_n asynchronous, active low, empties all stages.
// Depends on dcc_pkt_pkg, dcc_pkt_check, dcc_pkt_form, dcc_pkt_seal, dcc_pkt_serial.
module dcc_packet_builder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from bit 0: address[13:0], long_addr, byte_a, byte_b, byte_c, byte_d,
    // cv_number[9:0], cv_data, level, flag_bit, func_bits, zero fill
    input  logic [87:0] s_tdata,
    // req_type[4:0]
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // packet_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // rejected
    output logic        m_tuser
);
    import dcc_pkt_pkg::*;

    req_t  req;
    chk_t  chk;
    form_t form;
    pkt_t  pkt;
    logic  chk_valid;
    logic  chk_ready;
    logic  form_valid;
    logic  form_ready;
    logic  pkt_valid;
    logic  pkt_ready;

    always_comb
    begin
        req.req_type  = s_tuser;
        req.address   = s_tdata[13:0];
        req.long_addr = s_tdata[14];
        req.byte_a    = s_tdata[22:15];
        req.byte_b    = s_tdata[30:23];
        req.byte_c    = s_tdata[38:31];
        req.byte_d    = s_tdata[46:39];
        req.cv_number = s_tdata[56:47];
        req.cv_data   = s_tdata[64:57];
        req.level     = s_tdata[72:65];
        req.flag_bit  = s_tdata[73];
        req.func_bits = s_tdata[81:74];
    end

    dcc_pkt_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (req),
        .out_valid (chk_valid),
        .out_ready (chk_ready),
        .out_chk   (chk)
    );

    dcc_pkt_form u_form (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chk_valid),
        .in_ready  (chk_ready),
        .in_chk    (chk),
        .out_valid (form_valid),
        .out_ready (form_ready),
        .out_form  (form)
    );

    dcc_pkt_seal u_seal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (form_valid),
        .in_ready  (form_ready),
        .in_form   (form),
        .out_valid (pkt_valid),
        .out_ready (pkt_ready),
        .out_pkt   (pkt)
    );

    dcc_pkt_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pkt_valid),
        .in_ready  (pkt_ready),
        .in_pkt    (pkt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_rej   (m_tuser)
    );

endmodule
